@@ rtl/core/fixed_block_fit_allocator_macros.svh @@
// Assertion helpers shared by the allocator modules.
`ifndef FIXED_BLOCK_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_FIT_ALLOCATOR_MACROS_SVH

// Checked at every clock edge outside reset.
`define FBFA_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");

// Checked at every clock edge, reset included.
`define FBFA_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: check failed");

`endif

@@ rtl/core/fbfa_pkg.sv @@
package fbfa_pkg;

   // Operation codes.
   localparam logic [2:0] OP_INIT  = 3'd0;
   localparam logic [2:0] OP_ADD   = 3'd1;
   localparam logic [2:0] OP_FIRST = 3'd2;
   localparam logic [2:0] OP_BEST  = 3'd3;
   localparam logic [2:0] OP_WORST = 3'd4;
   localparam logic [2:0] OP_FREE  = 3'd5;

   // Result status codes.
   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam int SIZE_W = 32;
   localparam int SLOT_W = 4;

   typedef struct packed {
      logic load;
      logic scan_run;
      logic commit;
   } fbfa_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic scan_done;
   } fbfa_sts_type;

   function automatic logic op_scans(input logic [2:0] op);
      op_scans = (op == OP_FIRST) || (op == OP_BEST) || (op == OP_WORST) ||
                 (op == OP_FREE);
   endfunction

endpackage

@@ rtl/core/fbfa_cntl.sv @@
`include "fixed_block_fit_allocator_macros.svh"

module fbfa_cntl
   import fbfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [2:0]   req_operation,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output fbfa_cmd_type cmd,
   input  fbfa_sts_type sts
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_COMMIT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_open;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_open  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (op_scans(req_operation) && !sts.count_zero) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (rsp_open) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `FBFA_ASSERT(a_accept_leaves_idle, clock, reset, (state_ff == S_IDLE && req_valid) |=> (state_ff != S_IDLE))
   `FBFA_ASSERT(a_rsp_from_commit, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == S_COMMIT))
   `FBFA_ASSERT(a_no_scan_when_empty, clock, reset, (state_ff == S_SCAN) |-> !sts.count_zero)

endmodule

@@ rtl/core/fbfa_dpath.sv @@
`include "fixed_block_fit_allocator_macros.svh"

module fbfa_dpath
   import fbfa_pkg::*;
#(
   parameter int MAX_BLOCKS = 16
)(
   input  logic              clock,
   input  logic              reset,
   input  fbfa_cmd_type      cmd,
   output fbfa_sts_type      sts,
   input  logic [2:0]        req_operation,
   input  logic [SIZE_W-1:0] req_size,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [SIZE_W-1:0] rsp_chosen_size
);

   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

   // Each entry holds the free mark above the block size.
   logic [SIZE_W:0] mem [MAX_BLOCKS];

   logic [2:0]        op_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff;
   logic              issue_end_ff;
   logic              eval_vld_ff;
   logic [IDX_W-1:0]  eval_idx_ff;
   logic [SIZE_W:0]   rdata_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  pick_idx_ff;
   logic [SIZE_W-1:0] pick_size_ff;
   logic [1:0]        status_ff, status_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [SIZE_W-1:0] chosen_ff, chosen_in;

   logic [CNT_W-1:0]  count_m1;
   logic              rd_en;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [SIZE_W:0]   wr_data;
   logic              ent_free;
   logic [SIZE_W-1:0] ent_size;
   logic              is_first, is_best, is_worst, is_free, is_fit;
   logic              hit, take, stop;
   logic              full;

   assign count_m1 = count_ff - CNT_W'(1);
   assign full     = (count_ff == CNT_W'(MAX_BLOCKS));
   assign ent_free = rdata_ff[SIZE_W];
   assign ent_size = rdata_ff[SIZE_W-1:0];
   assign is_first = (op_ff == OP_FIRST);
   assign is_best  = (op_ff == OP_BEST);
   assign is_worst = (op_ff == OP_WORST);
   assign is_free  = (op_ff == OP_FREE);
   assign is_fit   = is_first || is_best || is_worst;

   assign hit  = eval_vld_ff &&
                 ((is_fit && ent_free && (ent_size >= size_ff)) ||
                  (is_free && !ent_free && (ent_size == size_ff)));
   assign take = hit && (!found_ff || is_first || is_free ||
                         (is_best && (ent_size < pick_size_ff)) ||
                         (is_worst && (ent_size > pick_size_ff)));
   assign stop = hit && (is_first || is_free);
   assign rd_en = cmd.scan_run && !issue_end_ff;

   assign sts.count_zero = (count_ff == '0);
   assign sts.scan_done  = stop || issue_end_ff;

   // Commit: table write, count update and result.
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = '0;
      wr_data   = {1'b1, size_ff};
      count_in  = count_ff;
      status_in = ST_NONE;
      slot_in   = '0;
      chosen_in = '0;
      unique case (op_ff)
         OP_INIT: begin
            wr_en     = 1'b1;
            count_in  = CNT_W'(1);
            status_in = ST_DONE;
            chosen_in = size_ff;
         end
         OP_ADD: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en     = 1'b1;
               wr_addr   = count_ff[IDX_W-1:0];
               count_in  = count_ff + CNT_W'(1);
               status_in = ST_DONE;
               slot_in   = SLOT_W'(count_ff);
               chosen_in = size_ff;
            end
         end
         OP_FIRST, OP_BEST, OP_WORST, OP_FREE: begin
            if (found_ff) begin
               wr_en     = 1'b1;
               wr_addr   = pick_idx_ff;
               wr_data   = {is_free, pick_size_ff};
               status_in = ST_DONE;
               slot_in   = SLOT_W'(pick_idx_ff);
               chosen_in = pick_size_ff;
            end
         end
         default: begin
            status_in = ST_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[idx_ff];
      end
      if (cmd.commit && wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         issue_end_ff <= 1'b0;
         eval_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         if (cmd.load) begin
            issue_end_ff <= 1'b0;
            eval_vld_ff  <= 1'b0;
            found_ff     <= 1'b0;
         end else if (cmd.scan_run) begin
            eval_vld_ff <= rd_en;
            if (rd_en && (idx_ff == '0)) begin
               issue_end_ff <= 1'b1;
            end
            if (take) begin
               found_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         size_ff <= req_size;
         idx_ff  <= count_m1[IDX_W-1:0];
      end else if (rd_en) begin
         idx_ff      <= idx_ff - IDX_W'(1);
         eval_idx_ff <= idx_ff;
      end
      if (cmd.scan_run && take) begin
         pick_idx_ff  <= eval_idx_ff;
         pick_size_ff <= ent_size;
      end
      if (cmd.commit) begin
         status_ff <= status_in;
         slot_ff   <= slot_in;
         chosen_ff <= chosen_in;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_chosen_size = chosen_ff;

   `FBFA_ASSERT_ALWAYS(a_count_bound, clock, reset || (count_ff <= CNT_W'(MAX_BLOCKS)))
   `FBFA_ASSERT(a_fit_pick_large, clock, reset, (found_ff && is_fit) |-> (pick_size_ff >= size_ff))
   `FBFA_ASSERT(a_free_pick_exact, clock, reset, (found_ff && is_free) |-> (pick_size_ff == size_ff))

endmodule

@@ rtl/core/fixed_block_fit_allocator.sv @@
// Fixed block fit allocator.
// A table of up to MAX_BLOCKS memory blocks, each a size and a free mark.
// Each request transaction on the req_ channel carries an operation (init,
// add, first fit, best fit, worst fit, free) and a size; each one yields
// exactly one response transaction on the rsp_ channel with a status, the
// slot touched and the size of that block. A transaction moves at a rising
// edge where valid is high and stall is low.
// Init and add go from acceptance straight to the commit step, which
// writes the response register. A fit or free on a non-empty table walks
// the table newest to oldest through one synchronous read port, one entry
// per cycle; a first fit or free ends at its match.
// The next request is taken as soon as the previous one has reached the
// response register, even while that response is still stalled.
// A stalled response holds its payload; a finished operation then waits in
// its commit step until the response register is free.
// Reset empties the table (count zero) and clears the response valid; the
// table contents need no clearing, since only entries below the count are
// ever read.
module fixed_block_fit_allocator
   import fbfa_pkg::*;
#(
   parameter int MAX_BLOCKS = 16
)(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_operation,
   input  logic [SIZE_W-1:0] req_size,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot,
   output logic [SIZE_W-1:0] rsp_chosen_size
);

   // Commands from the controller and status back from the datapath.
   fbfa_cmd_type cmd;
   fbfa_sts_type sts;

   // The controller sequences load, table walk and commit.
   fbfa_cntl u_cntl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .sts           (sts)
   );

   // The datapath holds the block table, the walk pointer, the current pick
   // and the response payload register.
   fbfa_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_operation   (req_operation),
      .req_size        (req_size),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_chosen_size (rsp_chosen_size)
   );

endmodule
